// ===== src/hav_pkg.sv =====
`default_nettype none
package hav_pkg;

  // angle and vector widths inside the datapath
  localparam int ZW = 36;
  localparam int XW = 36;
  localparam int SQ_STEPS = 32;
  localparam int TABLE_LEN = 40;

  localparam logic [1:0] REG_REF_LAT = 2'd0;
  localparam logic [1:0] REG_REF_LON = 2'd1;
  localparam logic [1:0] REG_RADIUS  = 2'd2;

  localparam logic [30:0] RAD_PER_UNIT_Q60 = 31'd2012227627;
  localparam logic signed [XW-1:0] KINV_Q32 = 36'sd2608131496;
  localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic [22:0] EARTH_RADIUS_M = 23'd6371000;
  localparam logic [24:0] DIST_MAX_M = 25'd20015087;

  typedef struct packed {
    logic signed [30:0] point_lat;
    logic signed [31:0] point_lon;
  } hav_in_t;

  typedef struct packed {
    logic [24:0] distance_m;
    logic        within_radius;
  } hav_out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } hav_cv_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } hav_sq_t;

  // atan(2^-i) in Q30, floored
  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0: v = 30'd843314856;
      1: v = 30'd497837829;
      2: v = 30'd263043836;
      3: v = 30'd133525158;
      4: v = 30'd67021686;
      5: v = 30'd33543515;
      6: v = 30'd16775850;
      7: v = 30'd8388437;
      8: v = 30'd4194282;
      9: v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd7;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/hav_cordic_cell.sv =====
`default_nettype none
module hav_cordic_cell import hav_pkg::*; #(
  parameter int STEP = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic    clk,
  input  hav_cv_t din,
  output hav_cv_t dout
);

  localparam logic signed [ZW-1:0] ANGLE = ZW'(atan_q30(STEP));

  logic signed [XW-1:0] xi, yi, xs, ys;
  logic signed [ZW-1:0] zi;
  logic dir;
  hav_cv_t nxt;

  always_comb begin
    xi = din.x;
    yi = din.y;
    zi = din.z;
    xs = xi >>> STEP;
    ys = yi >>> STEP;
    dir = VECTORING ? (yi < 0) : (zi >= 0);
    if (dir) begin
      nxt.x = xi - ys;
      nxt.y = yi + xs;
      nxt.z = zi - ANGLE;
    end else begin
      nxt.x = xi + ys;
      nxt.y = yi - xs;
      nxt.z = zi + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule
`default_nettype wire

// ===== src/hav_sqrt_cell.sv =====
`default_nettype none
module hav_sqrt_cell import hav_pkg::*; #(
  parameter int K = 31
) (
  input  logic    clk,
  input  hav_sq_t din,
  output hav_sq_t dout
);

  logic [65:0] rem_w, trial;
  hav_sq_t nxt;

  // one root bit per cell, restoring
  always_comb begin
    rem_w = {2'b00, din.rem};
    trial = ({34'd0, din.root} << (K + 1)) + (66'd1 << (2 * K));
    nxt = din;
    if (rem_w >= trial) begin
      nxt.rem = 64'(rem_w - trial);
      nxt.root = din.root | (32'd1 << K);
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule
`default_nettype wire

// ===== src/haversine_distance_radius_filter_core.sv =====
`default_nettype none
// Channel   Signals                              Beat taken when
// point     start, busy, point                   start && !busy at clk rise
// result    result_valid, result                 result_valid (one cycle)
// config    psel penable pwrite paddr pwdata     psel && penable && pwrite
//           prdata pready
//
// One point per cycle, every cycle; busy never rises.
// Pipeline depth is set by the two CORDIC chains (sin/cos and atan2)
// and the 32-cell square root chain.
// rst is synchronous and clears the configuration registers and the valid line.
// The receiver cannot stall: each result is shown for exactly one cycle.
module haversine_distance_radius_filter_core import hav_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  hav_in_t     point,
  output logic        result_valid,
  output hav_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N = CORDIC_STEPS;
  localparam int LAT = 43 + 2 * N;

  // ---------------- configuration ----------------
  logic signed [30:0] ref_lat;
  logic signed [31:0] ref_lon;
  logic [24:0] radius_limit_m;

  assign pready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_lat <= '0;
      ref_lon <= '0;
      radius_limit_m <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_REF_LAT: ref_lat <= pwdata[30:0];
        REG_REF_LON: ref_lon <= pwdata;
        REG_RADIUS:  radius_limit_m <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_REF_LAT: prdata = {1'b0, ref_lat};
      REG_REF_LON: prdata = ref_lon;
      REG_RADIUS:  prdata = {7'd0, radius_limit_m};
      default:     prdata = '0;
    endcase
  end

  // ---------------- valid line ----------------
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  assign result_valid = vld[LAT-1];

  // ---------------- helpers ----------------
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // (a*b + 2^31) >> 32, operands up to 2^32
  function automatic logic [32:0] mul_rnd(input logic [32:0] a, input logic [32:0] b);
    logic [65:0] p;
    p = 66'(a) * 66'(b) + (66'd1 << 31);
    return 33'(p >> 32);
  endfunction

  function automatic logic signed [33:0] clamp1(input logic signed [XW-1:0] v);
    if (v > 36'sd4294967296) return 34'sd4294967296;
    if (v < -36'sd4294967296) return -34'sd4294967296;
    return 34'(v);
  endfunction

  // ---------------- S0: input beat ----------------
  logic signed [30:0] p_lat;
  logic signed [31:0] p_lon;

  always_ff @(posedge clk) begin
    p_lat <= point.point_lat;
    p_lon <= point.point_lon;
  end

  // ---------------- S1: differences, magnitudes ----------------
  // lanes: 0 half dlat, 1 half dlon, 2 ref lat, 3 point lat
  logic [32:0] ang_mag [4];
  logic [3:0] ang_neg;
  logic signed [32:0] dlat, dlon;

  always_comb begin
    dlat = 33'(p_lat) - 33'(ref_lat);
    dlon = 33'(p_lon) - 33'(ref_lon);
  end

  always_ff @(posedge clk) begin
    ang_mag[0] <= mag33(dlat);
    ang_mag[1] <= mag33(dlon);
    ang_mag[2] <= mag33(33'(ref_lat));
    ang_mag[3] <= mag33(33'(p_lat));
    ang_neg <= {p_lat[30], ref_lat[30], dlon[32], dlat[32]};
  end

  // ---------------- S2: units to Q30 radians ----------------
  logic [32:0] rad_mag [4];
  logic [3:0] rad_neg;
  logic [64:0] rad_sum [4];

  always_comb begin
    for (int u = 0; u < 4; u++) begin
      rad_sum[u] = 65'(ang_mag[u]) * 65'(RAD_PER_UNIT_Q60)
                 + ((u < 2) ? (65'd1 << 30) : (65'd1 << 29));
    end
  end

  always_ff @(posedge clk) begin
    for (int u = 0; u < 4; u++) begin
      rad_mag[u] <= (u < 2) ? 33'(rad_sum[u] >> 31) : 33'(rad_sum[u] >> 30);
    end
    rad_neg <= ang_neg;
  end

  // ---------------- S3: sign, range reduction, fold ----------------
  logic signed [ZW-1:0] z_red [4];
  logic [3:0] fold_neg;
  logic signed [ZW-1:0] s3_z [4];
  logic [3:0] s3_neg;

  always_comb begin
    for (int u = 0; u < 4; u++) begin
      z_red[u] = rad_neg[u] ? -signed'({3'b000, rad_mag[u]}) : signed'({3'b000, rad_mag[u]});
      if (z_red[u] > PI_Q30) begin
        z_red[u] = z_red[u] - TWO_PI_Q30;
      end else if (z_red[u] < -PI_Q30) begin
        z_red[u] = z_red[u] + TWO_PI_Q30;
      end
      fold_neg[u] = 1'b0;
      if (z_red[u] > HALF_PI_Q30) begin
        z_red[u] = z_red[u] - PI_Q30;
        fold_neg[u] = 1'b1;
      end else if (z_red[u] < -HALF_PI_Q30) begin
        z_red[u] = z_red[u] + PI_Q30;
        fold_neg[u] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_z <= z_red;
    s3_neg <= fold_neg;
  end

  // ---------------- sin/cos chains, four lanes ----------------
  hav_cv_t cs [4][N+1];
  logic [3:0] neg_pipe [N];

  for (genvar u = 0; u < 4; u++) begin : g_sc
    assign cs[u][0] = '{x: KINV_Q32, y: '0, z: s3_z[u]};
    for (genvar j = 0; j < N; j++) begin : g_cell
      hav_cordic_cell #(.STEP(j), .VECTORING(1'b0)) u_cell (
        .clk  (clk),
        .din  (cs[u][j]),
        .dout (cs[u][j+1])
      );
    end
  end

  // fold sign travels alongside the rotation cells
  always_ff @(posedge clk) begin
    neg_pipe[0] <= s3_neg;
    for (int j = 1; j < N; j++) begin
      neg_pipe[j] <= neg_pipe[j-1];
    end
  end

  // ---------------- SA: clamp, sign ----------------
  logic [32:0] ms_dlat, ms_dlon;
  logic signed [33:0] c1, c2;
  logic signed [33:0] cx1, cx2, sy0, sy1;

  always_comb begin
    sy0 = clamp1(cs[0][N].y);
    sy1 = clamp1(cs[1][N].y);
    cx1 = clamp1(cs[2][N].x);
    cx2 = clamp1(cs[3][N].x);
  end

  always_ff @(posedge clk) begin
    ms_dlat <= 33'(sy0[33] ? -sy0 : sy0);
    ms_dlon <= 33'(sy1[33] ? -sy1 : sy1);
    c1 <= neg_pipe[N-1][2] ? -cx1 : cx1;
    c2 <= neg_pipe[N-1][3] ? -cx2 : cx2;
  end

  // ---------------- SB: squares and cos product ----------------
  logic [32:0] sq_lat, sq_lon, cc_mag;
  logic cc_neg;

  always_ff @(posedge clk) begin
    sq_lat <= mul_rnd(ms_dlat, ms_dlat);
    sq_lon <= mul_rnd(ms_dlon, ms_dlon);
    cc_mag <= mul_rnd(33'(c1[33] ? -c1 : c1), 33'(c2[33] ? -c2 : c2));
    cc_neg <= c1[33] ^ c2[33];
  end

  // ---------------- SC: cos product times lon square ----------------
  logic [32:0] sc_lat, t_mag;
  logic t_neg;

  always_ff @(posedge clk) begin
    sc_lat <= sq_lat;
    t_mag <= mul_rnd(cc_mag, sq_lon);
    t_neg <= cc_neg;
  end

  // ---------------- SD: a, clamped to [0, 1] ----------------
  logic signed [35:0] a_sum;
  logic [32:0] a_q, sd_a;

  always_comb begin
    a_sum = signed'({3'b000, sc_lat})
          + (t_neg ? -signed'({3'b000, t_mag}) : signed'({3'b000, t_mag}));
    if (a_sum < 0) begin
      a_q = '0;
    end else if (a_sum > 36'sd4294967296) begin
      a_q = 33'h1_0000_0000;
    end else begin
      a_q = 33'(a_sum);
    end
  end

  always_ff @(posedge clk) begin
    sd_a <= a_q;
  end

  // ---------------- square roots of a and 1-a ----------------
  hav_sq_t sq [2][SQ_STEPS+1];
  logic [1:0] sat_pipe [SQ_STEPS];
  logic [32:0] one_minus_a;

  assign one_minus_a = 33'h1_0000_0000 - sd_a;
  assign sq[0][0] = '{rem: {sd_a[31:0], 32'd0}, root: '0};
  assign sq[1][0] = '{rem: {one_minus_a[31:0], 32'd0}, root: '0};

  for (genvar r = 0; r < 2; r++) begin : g_sq
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_cell
      hav_sqrt_cell #(.K(SQ_STEPS - 1 - j)) u_cell (
        .clk  (clk),
        .din  (sq[r][j]),
        .dout (sq[r][j+1])
      );
    end
  end

  // a full-scale operand gives a root of exactly one
  always_ff @(posedge clk) begin
    sat_pipe[0] <= {sd_a == '0, sd_a[32]};
    for (int j = 1; j < SQ_STEPS; j++) begin
      sat_pipe[j] <= sat_pipe[j-1];
    end
  end

  // ---------------- atan2 vectoring chain ----------------
  hav_cv_t vc [N+1];
  logic signed [XW-1:0] root_a, root_b;

  always_comb begin
    root_a = sat_pipe[SQ_STEPS-1][0] ? 36'sd4294967296
                                     : signed'({4'd0, sq[0][SQ_STEPS].root});
    root_b = sat_pipe[SQ_STEPS-1][1] ? 36'sd4294967296
                                     : signed'({4'd0, sq[1][SQ_STEPS].root});
  end

  assign vc[0] = '{x: root_b, y: root_a, z: '0};

  for (genvar j = 0; j < N; j++) begin : g_vec
    hav_cordic_cell #(.STEP(j), .VECTORING(1'b1)) u_cell (
      .clk  (clk),
      .din  (vc[j]),
      .dout (vc[j+1])
    );
  end

  // ---------------- E, F, G: scale to metres ----------------
  logic signed [ZW:0] c_dbl;
  logic [33:0] c_ang;
  logic [57:0] dist_prod;
  logic [27:0] dist_raw;
  logic [24:0] dist_sat;

  assign c_dbl = 37'(vc[N].z) <<< 1;

  always_ff @(posedge clk) begin
    c_ang <= c_dbl[ZW] ? '0 : 34'(c_dbl);
  end

  always_ff @(posedge clk) begin
    dist_prod <= 58'(c_ang) * 58'(EARTH_RADIUS_M) + (58'd1 << 29);
  end

  always_comb begin
    dist_raw = 28'(dist_prod >> 30);
    dist_sat = (dist_raw > 28'(DIST_MAX_M)) ? DIST_MAX_M : dist_raw[24:0];
  end

  always_ff @(posedge clk) begin
    result.distance_m <= dist_sat;
    result.within_radius <= (dist_sat <= radius_limit_m);
  end

`ifndef SYNTH
  // every result comes from a point taken exactly one latency earlier
  a_lat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LAT))
    else $error("result without matching input beat");

  a_within: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.within_radius == (result.distance_m <= radius_limit_m)))
    else $error("radius flag disagrees with distance");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.distance_m <= DIST_MAX_M))
    else $error("distance above half circumference");
`endif

endmodule
`default_nettype wire
